[rtl/sppd_pkg.sv]
// ----------------------------------------------------------------------------
// sppd_pkg
// Types, widths and command codes shared by the polygon distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package sppd_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;

  // Coordinate differences, pair sums, magnitudes and fractions.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PAIR_W  = 2 * COORD_BITS + 3;
  localparam int MAG_W   = 2 * COORD_BITS + 1;
  localparam int DEN_W   = MAG_W;
  localparam int NUM_W   = 2 * MAG_W;
  localparam int LACC_W  = NUM_W + DEN_W;

  // Final divide and root.
  localparam int QW      = NUM_W + 2 * FRAC_BITS;
  localparam int SQ_W    = (QW + 1) / 2;
  localparam int CNT_W   = $clog2(QW);

  localparam int DIST_W   = 18;
  localparam int DIST_MAX = (1 << (DIST_W - 1)) - 1;

  localparam logic CFG_QUERY_X = 1'b0;
  localparam logic CFG_QUERY_Y = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic                  final_vertex;
  } in_req_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] signed_distance;
    logic [COORD_BITS-1:0]    nearest_x;
    logic [COORD_BITS-1:0]    nearest_y;
  } out_req_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_TAKE, CMD_CLOSE, CMD_DIFF,
    CMD_DOT1, CMD_DOT2, CMD_D1SQ, CMD_D2SQ, CMD_CROSS, CMD_LEN,
    CMD_SQR, CMD_PICK, CMD_C1, CMD_C2, CMD_C3, CMD_C4, CMD_C5, CMD_UPD,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_SQ_INIT, CMD_SQ_STEP, CMD_EMIT
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLOSE, ST_DIFF,
    ST_DOT1, ST_DOT2, ST_D1SQ, ST_D2SQ, ST_CROSS, ST_LEN,
    ST_SQR, ST_PICK, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_UPD,
    ST_DIV_INIT, ST_DIV, ST_SQ_INIT, ST_SQ, ST_EMIT
  } state_e;

  typedef struct packed {
    logic at_start;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/sppd_ctrl.sv]
// ----------------------------------------------------------------------------
// sppd_ctrl
// Sequencer: walks each segment through the datapath, then divide and root.
// ----------------------------------------------------------------------------
`default_nettype none

module sppd_ctrl
  import sppd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_final_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output cmd_e            cmd_o
);

  state_e             state_q, state_d;
  logic               closing_q, closing_d;
  logic               fin_q, fin_d;
  logic               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      closing_q   <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      closing_q   <= closing_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    closing_d   = closing_q;
    fin_d       = fin_q;
    cnt_d       = cnt_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o     = CMD_TAKE;
          fin_d     = in_final_i;
          closing_d = 1'b0;
          if (status_i.at_start) begin
            if (in_final_i) state_d = ST_CLOSE;
          end else begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_CLOSE: begin
        cmd_o     = CMD_CLOSE;
        closing_d = 1'b1;
        state_d   = ST_DIFF;
      end
      ST_DIFF:  begin cmd_o = CMD_DIFF;  state_d = ST_DOT1;  end
      ST_DOT1:  begin cmd_o = CMD_DOT1;  state_d = ST_DOT2;  end
      ST_DOT2:  begin cmd_o = CMD_DOT2;  state_d = ST_D1SQ;  end
      ST_D1SQ:  begin cmd_o = CMD_D1SQ;  state_d = ST_D2SQ;  end
      ST_D2SQ:  begin cmd_o = CMD_D2SQ;  state_d = ST_CROSS; end
      ST_CROSS: begin cmd_o = CMD_CROSS; state_d = ST_LEN;   end
      ST_LEN:   begin cmd_o = CMD_LEN;   state_d = ST_SQR;   end
      ST_SQR:   begin cmd_o = CMD_SQR;   state_d = ST_PICK;  end
      ST_PICK:  begin cmd_o = CMD_PICK;  state_d = ST_C1;    end
      ST_C1:    begin cmd_o = CMD_C1;    state_d = ST_C2;    end
      ST_C2:    begin cmd_o = CMD_C2;    state_d = ST_C3;    end
      ST_C3:    begin cmd_o = CMD_C3;    state_d = ST_C4;    end
      ST_C4:    begin cmd_o = CMD_C4;    state_d = ST_C5;    end
      ST_C5:    begin cmd_o = CMD_C5;    state_d = ST_UPD;   end
      ST_UPD: begin
        cmd_o = CMD_UPD;
        if (closing_q)  state_d = ST_DIV_INIT;
        else if (fin_q) state_d = ST_CLOSE;
        else            state_d = ST_IDLE;
      end
      ST_DIV_INIT: begin
        cmd_o   = CMD_DIV_INIT;
        cnt_d   = CNT_W'(QW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o = CMD_DIV_STEP;
        if (cnt_q == '0) state_d = ST_SQ_INIT;
        else             cnt_d   = cnt_q - 1'b1;
      end
      ST_SQ_INIT: begin
        cmd_o   = CMD_SQ_INIT;
        cnt_d   = CNT_W'(SQ_W - 1);
        state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o = CMD_SQ_STEP;
        if (cnt_q == '0) state_d = ST_EMIT;
        else             cnt_d   = cnt_q - 1'b1;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o       = CMD_EMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/sppd_dp.sv]
// ----------------------------------------------------------------------------
// sppd_dp
// Datapath: segment distance fraction, best tracking, crossing parity,
// restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module sppd_dp
  import sppd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_data_i,
  input  wire in_req_t               in_data_i,
  input  wire cmd_e                  cmd_i,
  output dp_status_t                 status_o,
  output out_req_t                   out_data_o
);

  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic                  at_start_q;
  logic [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic                  ties_q;

  logic signed [DIFF_W-1:0] dx_q, dy_q, dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [PAIR_W-1:0] dot1_q, dot2_q, d1sq_q, d2sq_q, cross_q, len_q;
  logic [NUM_W-1:0]         prod_q, num_q;
  logic [DEN_W-1:0]         den_q;
  logic [LACC_W-1:0]        lacc_q, racc_q;

  logic                  best_valid_q;
  logic [NUM_W-1:0]      best_num_q;
  logic [DEN_W-1:0]      best_den_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q;
  logic                  parity_q;

  logic [DEN_W-1:0]      rem_q;
  logic [QW-1:0]         quo_q;
  logic [2*SQ_W-1:0]     rad_q;
  logic [SQ_W+1:0]       srem_q;
  logic [SQ_W-1:0]       root_q;
  out_req_t              out_q;

  // Shared signed pair unit: a1*b1 + a2*b2.
  logic signed [DIFF_W-1:0]   pa1, pb1, pa2, pb2;
  logic signed [2*DIFF_W-1:0] pr1, pr2;
  logic signed [PAIR_W-1:0]   pair_sum;

  always_comb begin
    pa1 = dx1_q; pb1 = dx_q; pa2 = dy1_q; pb2 = dy_q;
    case (cmd_i)
      CMD_DOT2:  begin pa1 = dx2_q; pb1 = dx_q;  pa2 = dy2_q;  pb2 = dy_q;  end
      CMD_D1SQ:  begin pa1 = dx1_q; pb1 = dx1_q; pa2 = dy1_q;  pb2 = dy1_q; end
      CMD_D2SQ:  begin pa1 = dx2_q; pb1 = dx2_q; pa2 = dy2_q;  pb2 = dy2_q; end
      CMD_CROSS: begin pa1 = dy1_q; pb1 = dx_q;  pa2 = -dx1_q; pb2 = dy_q;  end
      CMD_LEN:   begin pa1 = dx_q;  pb1 = dx_q;  pa2 = dy_q;   pb2 = dy_q;  end
      default: ;
    endcase
  end

  assign pr1      = pa1 * pb1;
  assign pr2      = pa2 * pb2;
  assign pair_sum = PAIR_W'(pr1) + PAIR_W'(pr2);

  // Shared unsigned multiplier.
  logic [PAIR_W-1:0] cross_abs;
  logic [MAG_W-1:0]  ma, mb;
  logic [NUM_W-1:0]  mprod;

  assign cross_abs = cross_q[PAIR_W-1] ? PAIR_W'(-cross_q) : PAIR_W'(cross_q);

  always_comb begin
    ma = cross_abs[MAG_W-1:0];
    mb = cross_abs[MAG_W-1:0];
    case (cmd_i)
      CMD_C1: begin ma = num_q[MAG_W-1:0];          mb = best_den_q; end
      CMD_C2: begin ma = num_q[NUM_W-1:MAG_W];      mb = best_den_q; end
      CMD_C3: begin ma = best_num_q[MAG_W-1:0];     mb = den_q;      end
      CMD_C4: begin ma = best_num_q[NUM_W-1:MAG_W]; mb = den_q;      end
      default: ;
    endcase
  end

  assign mprod = ma * mb;

  // Crossing test for the current segment.
  logic skip, cr_pos, nearer;
  assign skip = ((ay_q <= qy_q) && (by_q <= qy_q)) ||
                ((ay_q >  qy_q) && (by_q >  qy_q)) ||
                ((ax_q <  qx_q) && (bx_q <  qx_q));
  assign cr_pos = (cross_q != '0) && (cross_q[PAIR_W-1] == dy_q[DIFF_W-1]);
  assign nearer = !best_valid_q || (lacc_q < racc_q) ||
                  (ties_q && (lacc_q == racc_q));

  // Divide and root steps.
  logic [DEN_W:0]    div_sh;
  logic [SQ_W+3:0]   sq_t;
  logic [SQ_W+3:0]   sq_trial;
  assign div_sh   = {rem_q, quo_q[QW-1]};
  assign sq_t     = {srem_q, rad_q[2*SQ_W-1 -: 2]};
  assign sq_trial = (SQ_W+4)'({root_q, 2'b01});

  logic [DIST_W-2:0] mag;
  assign mag = (root_q > SQ_W'(DIST_MAX)) ? (DIST_W-1)'(DIST_MAX) : root_q[DIST_W-2:0];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q         <= '0;
      qy_q         <= '0;
      at_start_q   <= 1'b1;
      best_valid_q <= 1'b0;
      parity_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_QUERY_X: qx_q <= cfg_data_i;
          CFG_QUERY_Y: qy_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i)
        CMD_TAKE: at_start_q <= 1'b0;
        CMD_UPD: begin
          if (nearer) best_valid_q <= 1'b1;
          if (!skip && cr_pos) parity_q <= ~parity_q;
        end
        CMD_EMIT: begin
          at_start_q   <= 1'b1;
          best_valid_q <= 1'b0;
          parity_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_TAKE: begin
        cur_x_q  <= in_data_i.vertex_x;
        cur_y_q  <= in_data_i.vertex_y;
        ax_q     <= prev_x_q;
        ay_q     <= prev_y_q;
        bx_q     <= in_data_i.vertex_x;
        by_q     <= in_data_i.vertex_y;
        prev_x_q <= in_data_i.vertex_x;
        prev_y_q <= in_data_i.vertex_y;
        ties_q   <= 1'b0;
        if (at_start_q) begin
          first_x_q <= in_data_i.vertex_x;
          first_y_q <= in_data_i.vertex_y;
        end
      end
      CMD_CLOSE: begin
        ax_q   <= cur_x_q;
        ay_q   <= cur_y_q;
        bx_q   <= first_x_q;
        by_q   <= first_y_q;
        ties_q <= 1'b1;
      end
      CMD_DIFF: begin
        dx_q  <= $signed({1'b0, bx_q}) - $signed({1'b0, ax_q});
        dy_q  <= $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
        dx1_q <= $signed({1'b0, qx_q}) - $signed({1'b0, ax_q});
        dy1_q <= $signed({1'b0, qy_q}) - $signed({1'b0, ay_q});
        dx2_q <= $signed({1'b0, qx_q}) - $signed({1'b0, bx_q});
        dy2_q <= $signed({1'b0, qy_q}) - $signed({1'b0, by_q});
      end
      CMD_DOT1:  dot1_q  <= pair_sum;
      CMD_DOT2:  dot2_q  <= pair_sum;
      CMD_D1SQ:  d1sq_q  <= pair_sum;
      CMD_D2SQ:  d2sq_q  <= pair_sum;
      CMD_CROSS: cross_q <= pair_sum;
      CMD_LEN:   len_q   <= pair_sum;
      CMD_SQR:   prod_q  <= mprod;
      CMD_PICK: begin
        // Before the start, past the end, or perpendicular foot.
        if (dot1_q <= 0) begin
          num_q <= NUM_W'(d1sq_q[DEN_W-1:0]);
          den_q <= DEN_W'(1);
        end else if (dot2_q >= 0) begin
          num_q <= NUM_W'(d2sq_q[DEN_W-1:0]);
          den_q <= DEN_W'(1);
        end else begin
          num_q <= prod_q;
          den_q <= len_q[DEN_W-1:0];
        end
      end
      CMD_C1: prod_q <= mprod;
      CMD_C2: begin
        lacc_q <= LACC_W'(prod_q);
        prod_q <= mprod;
      end
      CMD_C3: begin
        lacc_q <= lacc_q + (LACC_W'(prod_q) << MAG_W);
        prod_q <= mprod;
      end
      CMD_C4: begin
        racc_q <= LACC_W'(prod_q);
        prod_q <= mprod;
      end
      CMD_C5: racc_q <= racc_q + (LACC_W'(prod_q) << MAG_W);
      CMD_UPD: begin
        if (nearer) begin
          best_num_q <= num_q;
          best_den_q <= den_q;
          best_x_q   <= bx_q;
          best_y_q   <= by_q;
        end
      end
      CMD_DIV_INIT: begin
        rem_q <= '0;
        quo_q <= QW'(best_num_q) << (2 * FRAC_BITS);
      end
      CMD_DIV_STEP: begin
        if (div_sh >= {1'b0, best_den_q}) begin
          rem_q <= DEN_W'(div_sh - {1'b0, best_den_q});
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[DEN_W-1:0];
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      CMD_SQ_INIT: begin
        rad_q  <= (2*SQ_W)'(quo_q);
        srem_q <= '0;
        root_q <= '0;
      end
      CMD_SQ_STEP: begin
        rad_q <= {rad_q[2*SQ_W-3:0], 2'b00};
        if (sq_t >= sq_trial) begin
          srem_q <= (SQ_W+2)'(sq_t - sq_trial);
          root_q <= {root_q[SQ_W-2:0], 1'b1};
        end else begin
          srem_q <= sq_t[SQ_W+1:0];
          root_q <= {root_q[SQ_W-2:0], 1'b0};
        end
      end
      CMD_EMIT: begin
        out_q.signed_distance <= parity_q ? $signed({1'b0, mag})
                                          : -$signed({1'b0, mag});
        out_q.nearest_x       <= best_x_q;
        out_q.nearest_y       <= best_y_q;
      end
      default: ;
    endcase
  end

  assign status_o.at_start = at_start_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

[rtl/signed_point_polygon_distance.sv]
// ----------------------------------------------------------------------------
// signed_point_polygon_distance
// Signed distance from a query point to a streamed closed polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Write query_x (index 0) and query_y (index 1) through the cfg port while
//   idle. Stream polygon vertices on the input channel, one request each,
//   with final_vertex set on the last one. The closing segment back to the
//   first vertex is evaluated after the final vertex.
//   One result request per polygon: signed distance in 1/16 pixel units
//   (positive inside, negative outside, zero on an edge) plus the end vertex
//   of the nearest segment.
// Sequence:
//   The first vertex of a polygon is only stored; every later vertex runs one
//   pass of the segment sequence through the shared pair unit and
//   multiplier. The final vertex adds the closing segment, the restoring
//   divide, the square root and the load of the output register.
// Reset clears the query point and starts a new polygon. When the receiver
// stalls, the result holds in the output register; the next polygon's
// vertices are still accepted until its own result is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_point_polygon_distance
  import sppd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_req_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_req_t                   out_data_o
);

  cmd_e       cmd;
  dp_status_t status;

  // Sequence the segment work and the final divide and root.
  sppd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_final_i  (in_data_i.final_vertex),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the query point, polygon state and arithmetic.
  sppd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed point to polygon distance block. Streams
// random and hand-built polygons against several query points, predicts the
// signed distance and nearest end vertex per polygon, and checks each result.
// ----------------------------------------------------------------------------
module tb_top;
  import sppd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_idx;
  logic [COORD_BITS-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_req_t              out_data;

  signed_point_polygon_distance u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Predictor state: a copy of the block's running polygon state.
  logic [COORD_BITS-1:0] qx, qy;
  bit                    poly_open;
  logic [COORD_BITS-1:0] first_vx, first_vy, last_vx, last_vy;
  logic [127:0]          near_num;
  logic [63:0]           near_den;
  logic [COORD_BITS-1:0] near_vx, near_vy;
  bit                    inside_par;

  in_req_t  vertex_q[$];
  out_req_t dist_q[$];
  int       fails;
  bit       stim_done;
  bit       hold_sender;

  task automatic clear_polygon();
    poly_open  = 1'b0;
    first_vx   = '0;
    first_vy   = '0;
    last_vx    = '0;
    last_vy    = '0;
    near_num   = '1;
    near_den   = 64'd1;
    near_vx    = '0;
    near_vy    = '0;
    inside_par = 1'b0;
  endtask

  // Fold one segment a->b into the nearest-distance and crossing state.
  task automatic fold_segment(input logic [COORD_BITS-1:0] ax, ay, bx, by,
                              input bit take_ties);
    longint px, py, dx, dy, dx1, dy1, dx2, dy2, cr;
    logic [127:0] num;
    logic [63:0]  den;
    logic [191:0] lhs, rhs;
    px  = qx;  py = qy;
    dx  = longint'(bx) - longint'(ax);
    dy  = longint'(by) - longint'(ay);
    dx1 = px - ax; dy1 = py - ay;
    dx2 = px - bx; dy2 = py - by;
    den = 64'd1;
    cr  = dy1 * dx - dx1 * dy;
    if (dx1 * dx + dy1 * dy <= 0) begin
      num = 128'(dx1 * dx1 + dy1 * dy1);
    end else if (dx2 * dx + dy2 * dy >= 0) begin
      num = 128'(dx2 * dx2 + dy2 * dy2);
    end else begin
      num = 128'(cr < 0 ? -cr : cr);
      num = num * num;
      den = 64'(dx * dx + dy * dy);
    end
    lhs = 192'(num) * 192'(near_den);
    rhs = 192'(near_num) * 192'(den);
    if (lhs < rhs || (take_ties && lhs == rhs)) begin
      near_num = num;
      near_den = den;
      near_vx  = bx;
      near_vy  = by;
    end
    // Ray crossing toward +x; skip segments that cannot cross.
    if ((ay <= qy && by <= qy) || (ay > qy && by > qy) || (ax < qx && bx < qx))
      return;
    if (dy < 0) cr = -cr;
    if (cr > 0) inside_par ^= 1'b1;
  endtask

  // floor(sqrt(num * 2^(2*FRAC_BITS) / den)) by bitwise search.
  function automatic longint unsigned fixed_root();
    logic [191:0] target;
    logic [191:0] t;
    longint unsigned r;
    target = 192'(near_num) << (2 * FRAC_BITS);
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      t = 192'(r | (64'd1 << b));
      if (t * t * 192'(near_den) <= target) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  task automatic predict_vertex(input in_req_t v);
    longint unsigned mag;
    out_req_t e;
    if (!poly_open) begin
      first_vx  = v.vertex_x;
      first_vy  = v.vertex_y;
      poly_open = 1'b1;
    end else begin
      fold_segment(last_vx, last_vy, v.vertex_x, v.vertex_y, 1'b0);
    end
    last_vx = v.vertex_x;
    last_vy = v.vertex_y;
    if (!v.final_vertex) return;
    fold_segment(v.vertex_x, v.vertex_y, first_vx, first_vy, 1'b1);
    mag = fixed_root();
    if (mag > DIST_MAX) mag = DIST_MAX;
    e.signed_distance = inside_par ? DIST_W'(mag) : -DIST_W'(mag);
    e.nearest_x = near_vx;
    e.nearest_y = near_vy;
    dist_q.push_back(e);
    clear_polygon();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Driver: hold the request while stalled, advance on acceptance.
  int in_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else if (in_valid && !in_stall) begin
      predict_vertex(in_data);
      void'(vertex_q.pop_front());
      if (vertex_q.size() != 0 && !hold_sender && gap_len() == 0) begin
        in_data <= vertex_q[0];
      end else begin
        in_valid <= 1'b0;
        in_gap   <= gap_len();
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (vertex_q.size() != 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_data  <= vertex_q[0];
      end
    end
  end

  // Monitor plus receiver stall generator.
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $error("result with no polygon pending: %p", out_data);
          fails++;
        end else begin
          out_req_t e;
          e = dist_q.pop_front();
          if (out_data.signed_distance !== e.signed_distance) begin
            $error("signed_distance exp %0d got %0d", e.signed_distance,
                   out_data.signed_distance);
            fails++;
          end
          if (out_data.nearest_x !== e.nearest_x) begin
            $error("nearest_x exp %0d got %0d", e.nearest_x, out_data.nearest_x);
            fails++;
          end
          if (out_data.nearest_y !== e.nearest_y) begin
            $error("nearest_y exp %0d got %0d", e.nearest_y, out_data.nearest_y);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= gap_len();
        out_stall  <= 1'b0;
      end
    end
  end

  function automatic in_req_t mk(int x, int y, bit fin);
    in_req_t v;
    v.vertex_x = COORD_BITS'(x);
    v.vertex_y = COORD_BITS'(y);
    v.final_vertex = fin;
    return v;
  endfunction

  // Random polygon, mostly small with a few long ones.
  task automatic push_polygon(int count_left);
    int n, cx, cy, rad;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
    if (n > count_left) n = count_left < 1 ? 1 : count_left;
    cx  = $urandom_range(0, 4095);
    cy  = $urandom_range(0, 4095);
    rad = 1 << $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      int x, y;
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end else begin
        x = cx + int'($urandom_range(0, 2 * rad)) - rad;
        y = cy + int'($urandom_range(0, 2 * rad)) - rad;
        x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
        y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
      end
      vertex_q.push_back(mk(x, y, i == n - 1));
    end
  endtask

  task automatic write_query(int x, int y);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_QUERY_X;
    cfg_data <= COORD_BITS'(x);
    @(posedge clk);
    cfg_idx  <= CFG_QUERY_Y;
    cfg_data <= COORD_BITS'(y);
    @(posedge clk);
    cfg_we   <= 1'b0;
    qx = COORD_BITS'(x);
    qy = COORD_BITS'(y);
  endtask

  // Wait for all queued vertices to go out and all results to return.
  task automatic drain();
    while (vertex_q.size() != 0 || in_valid || dist_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  int sent;
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = CFG_QUERY_X; cfg_data = '0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    fails = 0; stim_done = 1'b0; hold_sender = 1'b0;
    qx = '0; qy = '0;
    clear_polygon();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: square around the point (inside), point on an edge,
    // single vertex, repeated vertex, extreme coordinates.
    write_query(100, 100);
    vertex_q.push_back(mk(50, 50, 0));
    vertex_q.push_back(mk(150, 50, 0));
    vertex_q.push_back(mk(150, 150, 0));
    vertex_q.push_back(mk(50, 150, 1));
    vertex_q.push_back(mk(0, 100, 0));
    vertex_q.push_back(mk(200, 100, 0));
    vertex_q.push_back(mk(200, 300, 1));
    vertex_q.push_back(mk(4095, 4095, 1));
    vertex_q.push_back(mk(7, 9, 0));
    vertex_q.push_back(mk(7, 9, 0));
    vertex_q.push_back(mk(300, 9, 1));
    drain();
    write_query(0, 0);
    vertex_q.push_back(mk(4095, 4095, 1));
    vertex_q.push_back(mk(4095, 0, 0));
    vertex_q.push_back(mk(0, 4095, 1));
    drain();
    write_query(4095, 4095);
    vertex_q.push_back(mk(0, 0, 0));
    vertex_q.push_back(mk(4095, 0, 0));
    vertex_q.push_back(mk(0, 4095, 0));
    vertex_q.push_back(mk(4095, 4095, 1));
    vertex_q.push_back(mk(0, 0, 1));
    drain();

    // Random phases with a fresh query point each.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_query($urandom_range(0, 4095), $urandom_range(0, 4095));
      for (int k = 0; k < 300; ) begin
        int before_sz;
        before_sz = vertex_q.size();
        push_polygon(300 - k);
        k += vertex_q.size() - before_sz;
        // Hold the sender once until all results are back.
        if (ph == 2 && k > 150 && !hold_sender && sent == 0) begin
          sent = 1;
          hold_sender = 1'b1;
          while (dist_q.size() != 0 || in_valid) @(posedge clk);
          hold_sender = 1'b0;
        end
        while (vertex_q.size() > 40) @(posedge clk);
      end
      drain();
    end
    stim_done = 1'b1;
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
